/* design/aes_pkg.sv */
// Package with shared widths, types, constants and arithmetic helpers for the advantage scan.
`timescale 1ns / 1ps
package aes_pkg;

  localparam int VB = 32;
  localparam int CB = 16;
  localparam int PROD_W = VB + CB + 1;
  localparam int SCL_W = VB + 1;
  localparam int BASE_W = VB + 3;
  localparam int SUM_W = VB + 4;
  localparam int S_TDATA_W = ((3 * VB + 7) / 8) * 8;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = ((2 * VB + 7) / 8) * 8;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_USE_GAE     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DISCOUNT    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TRACE_DECAY = 2'd2;

  localparam logic          USE_GAE_RESET  = 1'b1;
  localparam logic [CB-1:0] DISCOUNT_RESET = 16'd64881;
  localparam logic [CB-1:0] DECAY_RESET    = 16'd62259;
  localparam longint GL_RESET_L = (longint'(DISCOUNT_RESET) * longint'(DECAY_RESET)
                                   + (longint'(1) << (CB - 1))) >> CB;
  localparam logic [CB-1:0] GL_RESET = CB'(GL_RESET_L);

  typedef struct packed {
    logic          use_gae;
    logic [CB-1:0] discount;
    logic [CB-1:0] gl;
  } cfg_t;

  typedef struct packed {
    logic                     restart;
    logic                     nonterminal;
    logic signed [BASE_W-1:0] base;
    logic signed [VB-1:0]     value;
    logic signed [VB-1:0]     acc_init;
  } q_entry_t;

  // Signed value times unsigned fraction, rounded to nearest with ties upward.
  function automatic logic signed [SCL_W-1:0] scale(input logic signed [VB-1:0] v,
                                                     input logic [CB-1:0] c);
    logic signed [PROD_W-1:0] p;
    p = v * $signed({1'b0, c});
    p = p + (PROD_W'(1) << (CB - 1));
    return SCL_W'(p >>> CB);
  endfunction

  function automatic logic signed [VB-1:0] sat(input logic signed [SUM_W-1:0] x);
    logic ovf;
    ovf = (|x[SUM_W-1:VB-1]) && !(&x[SUM_W-1:VB-1]);
    if (!ovf) begin
      return x[VB-1:0];
    end else if (x[SUM_W-1]) begin
      return {1'b1, {(VB-1){1'b0}}};
    end else begin
      return {1'b0, {(VB-1){1'b1}}};
    end
  endfunction

endpackage

/* design/aes_front.sv */
// Front part: accepts input words, tracks the following step and forms the loop-free terms.
`timescale 1ns / 1ps
module aes_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [aes_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic [aes_pkg::S_TUSER_W-1:0] s_tuser,
  input  aes_pkg::cfg_t                 cfg,
  output logic                          q_valid,
  input  logic                          q_ready,
  output aes_pkg::q_entry_t             q_data
);

  logic                          following_nonterminal;
  logic signed [aes_pkg::VB-1:0] following_value;
  logic                          first;
  logic                          start;
  logic                          boot_done;
  logic signed [aes_pkg::VB-1:0] reward;
  logic signed [aes_pkg::VB-1:0] value;
  logic signed [aes_pkg::VB-1:0] boot_value;
  logic signed [aes_pkg::VB-1:0] later_value;
  logic                          nonterminal;
  logic signed [aes_pkg::SCL_W-1:0] next_scaled;
  logic signed [aes_pkg::BASE_W-1:0] td_base;
  logic                          accept;

  assign first      = s_tuser[0];
  assign start      = s_tuser[1];
  assign boot_done  = s_tuser[2];
  assign reward     = s_tdata[aes_pkg::VB-1:0];
  assign value      = s_tdata[2*aes_pkg::VB-1:aes_pkg::VB];
  assign boot_value = s_tdata[3*aes_pkg::VB-1:2*aes_pkg::VB];

  assign s_tready = q_ready;
  assign q_valid  = s_tvalid;
  assign accept   = s_tvalid && q_ready;

  always_comb begin
    later_value = first ? boot_value : following_value;
    nonterminal = first ? !boot_done : following_nonterminal;
    next_scaled = aes_pkg::scale(later_value, cfg.discount);
    td_base     = aes_pkg::BASE_W'(reward) - aes_pkg::BASE_W'(value);
    if (nonterminal) begin
      td_base = td_base + aes_pkg::BASE_W'(next_scaled);
    end
    q_data.restart     = first;
    q_data.nonterminal = nonterminal;
    q_data.value       = value;
    if (cfg.use_gae) begin
      q_data.base     = td_base;
      q_data.acc_init = '0;
    end else begin
      q_data.base     = aes_pkg::BASE_W'(reward);
      q_data.acc_init = boot_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      following_value       <= '0;
      following_nonterminal <= 1'b0;
    end else if (accept) begin
      following_value       <= value;
      following_nonterminal <= !start;
    end
  end

endmodule

/* design/aes_queue.sv */
// Two-entry queue that decouples the front part from the accumulator loop.
`timescale 1ns / 1ps
module aes_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  aes_pkg::q_entry_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output aes_pkg::q_entry_t out_data
);

  aes_pkg::q_entry_t entries [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              push;
  logic              pop;

  assign in_ready  = !rst && (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

/* design/aes_back.sv */
// Back part: accumulator loop with saturation, then the second result and the output register.
`timescale 1ns / 1ps
module aes_back (
  input  logic                          clk,
  input  logic                          rst,
  input  aes_pkg::cfg_t                 cfg,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  aes_pkg::q_entry_t             q_data,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [aes_pkg::M_TDATA_W-1:0] m_tdata
);

  logic signed [aes_pkg::VB-1:0]    running_accumulator;
  logic                             a_valid;
  logic signed [aes_pkg::VB-1:0]    a_prim;
  logic signed [aes_pkg::VB-1:0]    a_value;
  logic signed [aes_pkg::VB-1:0]    advantage;
  logic signed [aes_pkg::VB-1:0]    return_target;
  logic signed [aes_pkg::VB-1:0]    acc_eff;
  logic [aes_pkg::CB-1:0]           coef;
  logic signed [aes_pkg::SCL_W-1:0] acc_scaled;
  logic signed [aes_pkg::SUM_W-1:0] sum;
  logic signed [aes_pkg::VB-1:0]    prim;
  logic signed [aes_pkg::VB-1:0]    advantage_next;
  logic signed [aes_pkg::VB-1:0]    return_target_next;
  logic                             b_ready;
  logic                             pop;

  assign b_ready = !m_tvalid || m_tready;
  assign q_ready = !a_valid || b_ready;
  assign pop     = q_valid && q_ready;

  always_comb begin
    acc_eff    = q_data.restart ? q_data.acc_init : running_accumulator;
    coef       = cfg.use_gae ? cfg.gl : cfg.discount;
    acc_scaled = aes_pkg::scale(acc_eff, coef);
    sum        = aes_pkg::SUM_W'(q_data.base);
    if (q_data.nonterminal) begin
      sum = sum + aes_pkg::SUM_W'(acc_scaled);
    end
    prim = aes_pkg::sat(sum);
  end

  always_comb begin
    if (cfg.use_gae) begin
      advantage_next     = a_prim;
      return_target_next = aes_pkg::sat(aes_pkg::SUM_W'(a_prim) + aes_pkg::SUM_W'(a_value));
    end else begin
      return_target_next = a_prim;
      advantage_next     = aes_pkg::sat(aes_pkg::SUM_W'(a_prim) - aes_pkg::SUM_W'(a_value));
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_prim  <= prim;
      a_value <= q_data.value;
    end
    if (a_valid && b_ready) begin
      advantage     <= advantage_next;
      return_target <= return_target_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_accumulator <= '0;
      a_valid             <= 1'b0;
      m_tvalid            <= 1'b0;
    end else begin
      if (pop) begin
        running_accumulator <= prim;
      end
      if (q_ready) begin
        a_valid <= q_valid;
      end
      if (b_ready) begin
        m_tvalid <= a_valid;
      end
    end
  end

  assign m_tdata = aes_pkg::M_TDATA_W'({return_target, advantage});

endmodule

/* design/advantage_estimation_scan_top.sv */
// Top level of the advantage scan: configuration registers, front, queue and back.
//
// Channel  Direction  Handshake           Payload
// s_       in         s_tvalid/s_tready   s_tdata, s_tuser (one rollout step)
// m_       out        m_tvalid/m_tready   m_tdata (advantage, return target)
// cfg_     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// One word is accepted per cycle; results pass the queue entry, a_prim and output registers.
// The rate is set by the accumulator loop in the back part: one multiply, add and
// saturate per cycle unless the output stalls.
// Synchronous reset restores config defaults and clears flags, pointers and carried state.
// The input stalls only in reset or when the two-entry queue is full; output stalls back up
// through the queue.
`timescale 1ns / 1ps
module advantage_estimation_scan_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // reward, value_estimate, bootstrap_value
  input  logic [aes_pkg::S_TDATA_W-1:0]   s_tdata,
  // first_in_sweep, episode_start, bootstrap_done
  input  logic [aes_pkg::S_TUSER_W-1:0]   s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // advantage, return_target
  output logic [aes_pkg::M_TDATA_W-1:0]   m_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [aes_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [aes_pkg::CB-1:0]          cfg_data
);

  logic                     use_gae;
  logic [aes_pkg::CB-1:0]   discount;
  logic [aes_pkg::CB-1:0]   trace_decay;
  logic [aes_pkg::CB-1:0]   gl;
  logic [2*aes_pkg::CB-1:0] gl_prod;
  logic [2*aes_pkg::CB-1:0] gl_next;
  aes_pkg::cfg_t            cfg;
  logic                     f_valid;
  logic                     f_ready;
  aes_pkg::q_entry_t        f_data;
  logic                     q_valid;
  logic                     q_ready;
  aes_pkg::q_entry_t        q_data;

  assign cfg_ready = !rst;
  assign gl_prod   = {{aes_pkg::CB{1'b0}}, discount} * {{aes_pkg::CB{1'b0}}, trace_decay};
  assign gl_next   = (gl_prod + (2*aes_pkg::CB)'(1 << (aes_pkg::CB - 1))) >> aes_pkg::CB;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_gae     <= aes_pkg::USE_GAE_RESET;
      discount    <= aes_pkg::DISCOUNT_RESET;
      trace_decay <= aes_pkg::DECAY_RESET;
      gl          <= aes_pkg::GL_RESET;
    end else begin
      gl <= gl_next[aes_pkg::CB-1:0];
      if (cfg_valid) begin
        unique case (cfg_index)
          aes_pkg::CFG_USE_GAE:     use_gae     <= cfg_data[0];
          aes_pkg::CFG_DISCOUNT:    discount    <= cfg_data;
          aes_pkg::CFG_TRACE_DECAY: trace_decay <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    cfg.use_gae  = use_gae;
    cfg.discount = discount;
    cfg.gl       = gl;
  end

  aes_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg      (cfg),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_data   (f_data)
  );

  aes_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  aes_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

`ifndef SYNTH
  a_push_fills_queue: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !q_valid) |=> q_valid)
    else $error("Accepted word did not reach the queue output.");

  a_queue_holds: assert property (@(posedge clk) disable iff (rst)
    (q_valid && !q_ready) |=> q_valid)
    else $error("Queue dropped a word that was not taken.");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("Output word valid right after reset.");
`endif

endmodule

/* test/tb_top.sv */
// Testbench for the advantage scan: directed and random steps checked against a two-mode predictor.
`timescale 1ns / 1ps
module tb_top;

  typedef logic signed [aes_pkg::VB-1:0] q16_t;

  typedef struct {
    logic first;
    q16_t reward;
    q16_t value;
    logic start;
    q16_t boot_value;
    logic boot_done;
  } rollout_step_t;

  typedef struct {
    q16_t advantage;
    q16_t return_target;
  } scan_result_t;

  localparam logic [aes_pkg::CFG_INDEX_W-1:0] CFG_NONE = 2'd3;
  localparam q16_t MAXV = 32'sh7FFF_FFFF;
  localparam q16_t MINV = 32'sh8000_0000;
  localparam q16_t Q_ONE = 32'sh0001_0000;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_AT_STEP = 437;
  localparam int HOLD_CYCLES = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [aes_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic [aes_pkg::S_TUSER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [aes_pkg::M_TDATA_W-1:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [aes_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [aes_pkg::CB-1:0] cfg_data = '0;

  advantage_estimation_scan_top dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  rollout_step_t rollout_q[$];
  scan_result_t predicted_scan[$];
  rollout_step_t step_on_bus;

  logic gae_mode = aes_pkg::USE_GAE_RESET;
  logic [aes_pkg::CB-1:0] gamma_r = aes_pkg::DISCOUNT_RESET;
  logic [aes_pkg::CB-1:0] lambda_r = aes_pkg::DECAY_RESET;
  q16_t later_value_q = '0;
  logic later_nonterminal_q = 1'b0;
  longint acc_q = 0;

  logic src_idle = 1'b1;
  logic sink_idle = 1'b1;
  logic sink_hold = 1'b0;
  int src_gap = 0;
  int sink_gap = 0;
  int steps_queued = 0;
  int steps_accepted = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  int err_count = 0;

  function automatic longint scale_q16(input longint v, input longint c);
    return (v * c + 64'sd32768) >>> 16;
  endfunction

  function automatic longint clamp_q16(input longint x);
    if (x > longint'(MAXV)) return longint'(MAXV);
    if (x < longint'(MINV)) return longint'(MINV);
    return x;
  endfunction

  function automatic scan_result_t predict_scan(input rollout_step_t st);
    longint next_v;
    longint acc;
    longint delta;
    longint gl_coef;
    longint adv;
    longint ret;
    logic nonterm;
    scan_result_t res;
    if (st.first) begin
      nonterm = !st.boot_done;
      next_v = st.boot_value;
      acc = gae_mode ? 0 : longint'(st.boot_value);
    end else begin
      nonterm = later_nonterminal_q;
      next_v = later_value_q;
      acc = acc_q;
    end
    if (gae_mode) begin
      gl_coef = (longint'(gamma_r) * longint'(lambda_r) + 64'sd32768) >>> 16;
      delta = longint'(st.reward) - longint'(st.value);
      if (nonterm) begin
        delta = delta + scale_q16(next_v, longint'(gamma_r)) + scale_q16(acc, gl_coef);
      end
      adv = clamp_q16(delta);
      ret = clamp_q16(adv + longint'(st.value));
      acc_q = adv;
    end else begin
      ret = longint'(st.reward);
      if (nonterm) begin
        ret = ret + scale_q16(acc, longint'(gamma_r));
      end
      ret = clamp_q16(ret);
      adv = clamp_q16(ret - longint'(st.value));
      acc_q = ret;
    end
    later_value_q = st.value;
    later_nonterminal_q = !st.start;
    res.advantage = adv[aes_pkg::VB-1:0];
    res.return_target = ret[aes_pkg::VB-1:0];
    return res;
  endfunction

  function automatic void note_error(input string msg);
    err_count++;
    if (err_count <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic void queue_step(input logic first, input q16_t reward, input q16_t value,
                                     input logic start, input q16_t boot_value,
                                     input logic boot_done);
    rollout_step_t st;
    st.first = first;
    st.reward = reward;
    st.value = value;
    st.start = start;
    st.boot_value = boot_value;
    st.boot_done = boot_done;
    rollout_q.insert(rollout_q.size(), st);
    steps_queued++;
  endfunction

  function automatic q16_t rand_q16();
    case ($urandom_range(0, 9)) inside
      0: begin
        return MAXV;
      end
      1: begin
        return MINV;
      end
      [2:4]: begin
        return $urandom;
      end
      default: begin
        return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      end
    endcase
  endfunction

  function automatic logic [aes_pkg::CB-1:0] rand_coef();
    case ($urandom_range(0, 4))
      0: begin
        return '0;
      end
      1: begin
        return '1;
      end
      2: begin
        return aes_pkg::DISCOUNT_RESET;
      end
      default: begin
        return aes_pkg::CB'($urandom_range(0, 65535));
      end
    endcase
  endfunction

  // Sender: presents queued rollout steps, with a drawn gap before the next one if src_idle.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predicted_scan.insert(predicted_scan.size(), predict_scan(step_on_bus));
        steps_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (rollout_q.size() != 0) begin
          step_on_bus = rollout_q[0];
          rollout_q.delete(0);
          s_tvalid <= 1'b1;
          s_tdata <= {step_on_bus.boot_value, step_on_bus.value, step_on_bus.reward};
          s_tuser <= {step_on_bus.boot_done, step_on_bus.start, step_on_bus.first};
          src_gap = src_idle ? $urandom_range(0, 3) : 0;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result word against the oldest prediction.
  always @(posedge clk) begin
    scan_result_t exp_res;
    q16_t got_adv;
    q16_t got_ret;
    if (rst) begin
      m_tready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_adv = m_tdata[aes_pkg::VB-1:0];
        got_ret = m_tdata[2*aes_pkg::VB-1:aes_pkg::VB];
        if (predicted_scan.size() == 0) begin
          note_error($sformatf("result %0d arrived with nothing outstanding: adv %h ret %h",
                               results_seen, got_adv, got_ret));
        end else begin
          exp_res = predicted_scan[0];
          predicted_scan.delete(0);
          if (got_adv !== exp_res.advantage) begin
            note_error($sformatf("result %0d advantage: expected %h, got %h",
                                 results_seen, exp_res.advantage, got_adv));
          end
          if (got_ret !== exp_res.return_target) begin
            note_error($sformatf("result %0d return target: expected %h, got %h",
                                 results_seen, exp_res.return_target, got_ret));
          end
        end
        results_seen++;
        sink_gap = sink_idle ? $urandom_range(0, 3) : 0;
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !sink_hold;
      end
    end
  end

  // Long receiver stall in the middle of a busy phase so that the input backs up.
  initial begin
    wait (steps_accepted >= HOLD_AT_STEP);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    sink_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[advantage_estimation_scan_top] ERROR");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (results_seen < steps_queued) begin
      @(posedge clk);
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [aes_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [aes_pkg::CB-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    case (idx)
      aes_pkg::CFG_USE_GAE: begin
        gae_mode = val[0];
      end
      aes_pkg::CFG_DISCOUNT: begin
        gamma_r = val;
      end
      aes_pkg::CFG_TRACE_DECAY: begin
        lambda_r = val;
      end
      default: begin
      end
    endcase
  endtask

  // Mostly proper sweeps of random length; some runs continue without a sweep start.
  task automatic random_phase(input int n_items);
    int left;
    int run_len;
    logic restart;
    src_idle = ($urandom_range(0, 3) != 0);
    sink_idle = ($urandom_range(0, 3) != 0);
    write_reg(aes_pkg::CFG_USE_GAE, aes_pkg::CB'($urandom_range(0, 65535)));
    write_reg(aes_pkg::CFG_DISCOUNT, rand_coef());
    write_reg(aes_pkg::CFG_TRACE_DECAY, rand_coef());
    if ($urandom_range(0, 3) == 0) begin
      write_reg(CFG_NONE, aes_pkg::CB'($urandom_range(0, 65535)));
    end
    left = n_items;
    while (left > 0) begin
      run_len = $urandom_range(1, 24);
      if (run_len > left) begin
        run_len = left;
      end
      restart = ($urandom_range(0, 9) != 0);
      for (int k = 0; k < run_len; k++) begin
        queue_step((k == 0) && restart, rand_q16(), rand_q16(), ($urandom_range(0, 11) == 0),
                   rand_q16(), ($urandom_range(0, 2) == 0));
      end
      left -= run_len;
    end
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Default settings, GAE mode; the first step arrives before any sweep start.
    queue_step(1'b0, Q_ONE, 32'sh0000_8000, 1'b0, '0, 1'b0);
    queue_step(1'b1, MAXV, MINV, 1'b0, MAXV, 1'b0);
    queue_step(1'b0, MINV, MAXV, 1'b1, MINV, 1'b1);
    queue_step(1'b0, '0, '0, 1'b0, '0, 1'b0);
    queue_step(1'b1, 32'shFFFE_8000, 32'sh0002_0000, 1'b0, MINV, 1'b1);
    queue_step(1'b0, 32'sh0000_4000, 32'shFFFF_0000, 1'b0, '0, 1'b0);
    wait_drained();

    // Plain returns; the sweep carries on across the mode change.
    write_reg(aes_pkg::CFG_USE_GAE, 16'd0);
    queue_step(1'b0, Q_ONE, 32'sh0003_0000, 1'b0, '0, 1'b0);
    queue_step(1'b1, MAXV, MINV, 1'b0, MAXV, 1'b0);
    queue_step(1'b0, MINV, MAXV, 1'b0, '0, 1'b0);
    queue_step(1'b0, MINV, MAXV, 1'b1, '0, 1'b0);
    queue_step(1'b1, 32'sh0000_8000, '0, 1'b0, 32'shFFF0_0000, 1'b0);
    wait_drained();

    // Largest coefficients, back to GAE, and a write to an unused index.
    write_reg(aes_pkg::CFG_DISCOUNT, 16'hFFFF);
    write_reg(aes_pkg::CFG_TRACE_DECAY, 16'hFFFF);
    write_reg(aes_pkg::CFG_USE_GAE, 16'd1);
    write_reg(CFG_NONE, 16'hFFFF);
    queue_step(1'b0, Q_ONE, '0, 1'b0, '0, 1'b0);
    queue_step(1'b1, 32'sh0010_0000, 32'sh0004_0000, 1'b0, MAXV, 1'b0);
    queue_step(1'b0, MAXV, MINV, 1'b0, '0, 1'b0);
    queue_step(1'b0, 32'sh0000_0001, 32'shFFFF_FFFF, 1'b0, '0, 1'b0);
    wait_drained();

    // Zero coefficients.
    write_reg(aes_pkg::CFG_DISCOUNT, 16'h0000);
    write_reg(aes_pkg::CFG_TRACE_DECAY, 16'h0000);
    queue_step(1'b1, Q_ONE, Q_ONE, 1'b0, MAXV, 1'b0);
    queue_step(1'b0, 32'shFFFF_FFFF, '0, 1'b0, '0, 1'b0);
    wait_drained();

    for (int p = 0; p < 9; p++) begin
      random_phase(100);
    end

    repeat (10) @(posedge clk);
    if (predicted_scan.size() != 0) begin
      note_error($sformatf("%0d results never arrived", predicted_scan.size()));
    end
    if (err_count == 0) begin
      $display("[advantage_estimation_scan_top] OK");
    end else begin
      $display("[advantage_estimation_scan_top] ERROR");
    end
    $finish;
  end

endmodule
